@@ rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// shared types and constants for the sine shape table lookup
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned AMP_W   = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned N_W     = 13;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 16;

  localparam int unsigned M_W     = 14;
  localparam int unsigned QUO_W   = 32;
  localparam int unsigned NUM_W   = M_W + QUO_W;
  localparam int unsigned REM_W   = 14;
  localparam int unsigned T_W     = 31;
  localparam int unsigned P_W     = 32;
  localparam int unsigned SIN_W   = 17;

  localparam logic [CFG_A_W-1:0] REG_AMPLITUDE   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SHAPE_MODE  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_SLICE_COUNT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FULL     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RISE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FALL     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MOUNTAIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BOUNCE   = 3'd4;

  localparam int unsigned N_COEF = 6;
  localparam logic [P_W-1:0] SIN_COEF [N_COEF] = '{
    32'd1686629713, 32'd693598669, 32'd85569306,
    32'd5026987, 32'd172272, 32'd3864
  };

  typedef struct packed {
    logic zero;
    logic base;
  } meta_t;

endpackage

@@ rtl/sst_div.sv @@
// ----------------------------------------------------------------------------
// sst_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module sst_div
  import sst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [N_W-1:0]   den_i,
  input  meta_t            meta_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output meta_t            meta_o
);

  logic             v_q    [QUO_W];
  logic [REM_W-1:0] r_q    [QUO_W];
  logic [QUO_W-1:0] lo_q   [QUO_W];
  logic [QUO_W-1:0] q_q    [QUO_W];
  logic [N_W-1:0]   n_q    [QUO_W];
  meta_t            meta_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] r_in;
    logic [QUO_W-1:0] lo_in;
    logic [QUO_W-1:0] q_in;
    logic [N_W-1:0]   n_in;
    meta_t            meta_in;
    logic [REM_W:0]   trial;
    logic             ge;
    logic [REM_W:0]   diff;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign r_in    = num_i[NUM_W-1:QUO_W];
      assign lo_in   = num_i[QUO_W-1:0];
      assign q_in    = '0;
      assign n_in    = den_i;
      assign meta_in = meta_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign r_in    = r_q[s-1];
      assign lo_in   = lo_q[s-1];
      assign q_in    = q_q[s-1];
      assign n_in    = n_q[s-1];
      assign meta_in = meta_q[s-1];
    end

    assign trial = {r_in, lo_in[QUO_W-1]};
    assign ge    = trial >= {{(REM_W+1-N_W){1'b0}}, n_in};
    assign diff  = trial - {{(REM_W+1-N_W){1'b0}}, n_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]    <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        lo_q[s]   <= {lo_in[QUO_W-2:0], 1'b0};
        q_q[s]    <= {q_in[QUO_W-2:0], ge};
        n_q[s]    <= n_in;
        meta_q[s] <= meta_in;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = q_q[QUO_W-1];
  assign meta_o  = meta_q[QUO_W-1];

endmodule

@@ rtl/sst_sine.sv @@
// ----------------------------------------------------------------------------
// sst_sine
// pipelined sine of a 32-bit phase, quadrant fold and horner polynomial
// ----------------------------------------------------------------------------
module sst_sine
  import sst_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [QUO_W-1:0]        frac_i,
  input  meta_t                   meta_i,
  output logic                    valid_o,
  output logic signed [SIN_W-1:0] sine_o,
  output logic                    zero_o
);

  localparam int unsigned NH = N_COEF - 1;
  localparam logic [T_W-1:0] ONE_Q30 = T_W'(1) << 30;

  // fold stage
  logic [QUO_W-1:0] phase;
  logic [T_W-1:0]   t_raw;
  logic             f_v_q, f_neg_q, f_zero_q;
  logic [T_W-1:0]   f_t_q;

  assign phase = meta_i.base ? frac_i + 32'h4000_0000 : frac_i;
  assign t_raw = {1'b0, phase[29:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en_i) begin
      f_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_t_q    <= phase[30] ? ONE_Q30 - t_raw : t_raw;
      f_neg_q  <= phase[31];
      f_zero_q <= meta_i.zero;
    end
  end

  // square stage
  logic [2*T_W-1:0] sq;
  logic             s_v_q, s_neg_q, s_zero_q;
  logic [T_W-1:0]   s_t_q, s_t2_q;

  assign sq = f_t_q * f_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (en_i) begin
      s_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_t_q    <= f_t_q;
      s_t2_q   <= sq[30+T_W-1:30];
      s_neg_q  <= f_neg_q;
      s_zero_q <= f_zero_q;
    end
  end

  // horner stages
  logic           h_v_q    [NH];
  logic           h_neg_q  [NH];
  logic           h_zero_q [NH];
  logic [T_W-1:0] h_t_q    [NH];
  logic [T_W-1:0] h_t2_q   [NH];
  logic [P_W-1:0] h_p_q    [NH];

  for (genvar h = 0; h < NH; h++) begin : g_horner
    logic               v_in, neg_in, zero_in;
    logic [T_W-1:0]     t_in, t2_in;
    logic [P_W-1:0]     p_in;
    logic [P_W+T_W-1:0] prod;
    logic [P_W:0]       acc;

    if (h == 0) begin : g_first
      assign v_in    = s_v_q;
      assign neg_in  = s_neg_q;
      assign zero_in = s_zero_q;
      assign t_in    = s_t_q;
      assign t2_in   = s_t2_q;
      assign p_in    = SIN_COEF[NH];
    end else begin : g_next
      assign v_in    = h_v_q[h-1];
      assign neg_in  = h_neg_q[h-1];
      assign zero_in = h_zero_q[h-1];
      assign t_in    = h_t_q[h-1];
      assign t2_in   = h_t2_q[h-1];
      assign p_in    = h_p_q[h-1];
    end

    assign prod = p_in * t2_in;
    assign acc  = {1'b0, SIN_COEF[NH-1-h]} - prod[P_W+T_W-1:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        h_v_q[h] <= 1'b0;
      end else if (en_i) begin
        h_v_q[h] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        h_neg_q[h]  <= neg_in;
        h_zero_q[h] <= zero_in;
        h_t_q[h]    <= t_in;
        h_t2_q[h]   <= t2_in;
        h_p_q[h]    <= acc[P_W-1:0];
      end
    end
  end

  // final product, rounding and cap
  logic [P_W+T_W-1:0] rprod;
  logic [P_W+T_W-31:0] r;
  logic [P_W+T_W-31:0] rr;
  logic [SIN_W-1:0]   mag;
  logic               o_v_q, o_zero_q;
  logic signed [SIN_W-1:0] o_sine_q;

  assign rprod = h_p_q[NH-1] * h_t_q[NH-1];
  assign r     = rprod[P_W+T_W-1:30];
  assign rr    = (r + (P_W+T_W-30)'(16384)) >> 15;
  assign mag   = (rr > (P_W+T_W-30)'(32768)) ? SIN_W'(32768) : rr[SIN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en_i) begin
      o_v_q <= h_v_q[NH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_sine_q <= h_neg_q[NH-1] ? -$signed(mag) : $signed(mag);
      o_zero_q <= h_zero_q[NH-1];
    end
  end

  assign valid_o = o_v_q;
  assign sine_o  = o_sine_q;
  assign zero_o  = o_zero_q;

endmodule

@@ rtl/sine_shape_table_lookup.sv @@
// an input passes the prep register, the divider, the sine unit and the output register in turn
// throughput: one lookup per cycle while the output is not stalled, through the 32-stage divider and 8-stage sine unit
// a stall on the output holds the whole pipeline in place
// reset clears all valid bits and sets amplitude 32767, shape full, 64 slices
// ----------------------------------------------------------------------------
// sine_shape_table_lookup
// computes amplitude times sine of a shape angle for one slice index
// ----------------------------------------------------------------------------
module sine_shape_table_lookup
  import sst_pkg::*;
#(
  parameter int unsigned MAX_SLICES = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_A_W-1:0]      cfg_index_i,
  input  logic [CFG_D_W-1:0]      cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IDX_W-1:0]        slice_index_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] shape_value_o
);

  logic signed [AMP_W-1:0] amplitude_q;
  logic [MODE_W-1:0]       shape_mode_q;
  logic [N_W-1:0]          slice_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q   <= 16'sd32767;
      shape_mode_q  <= MODE_FULL;
      slice_count_q <= 13'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_AMPLITUDE:   amplitude_q   <= cfg_wdata_i;
        REG_SHAPE_MODE:  shape_mode_q  <= cfg_wdata_i[MODE_W-1:0];
        REG_SLICE_COUNT: slice_count_q <= cfg_wdata_i[N_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  logic signed [OUT_W-1:0] shape_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // prep stage: clamp, numerator
  logic [N_W-1:0]   n;
  logic [N_W-1:0]   entries;
  logic [IDX_W-1:0] k;
  logic [M_W-1:0]   m;
  logic [5:0]       shift;
  logic [NUM_W-1:0] num;
  meta_t            meta;

  always_comb begin
    if (slice_count_q < N_W'(2)) begin
      n = N_W'(2);
    end else if (32'(slice_count_q) > MAX_SLICES) begin
      n = N_W'(MAX_SLICES);
    end else begin
      n = slice_count_q;
    end
    entries = (shape_mode_q == MODE_MOUNTAIN) ? n - N_W'(1) : n;
    k = (slice_index_i > IDX_W'(entries - N_W'(1))) ? IDX_W'(entries - N_W'(1))
                                                     : slice_index_i;
    meta.zero = (shape_mode_q > MODE_BOUNCE) ||
                ((shape_mode_q == MODE_FALL) && (k == IDX_W'(n - N_W'(1))));
    meta.base = (shape_mode_q == MODE_FALL) || (shape_mode_q == MODE_BOUNCE);
    case (shape_mode_q)
      MODE_FULL:     begin m = M_W'(k);          shift = 6'd32; end
      MODE_RISE:     begin m = M_W'(k) + M_W'(1); shift = 6'd30; end
      MODE_FALL:     begin m = M_W'(k);          shift = 6'd30; end
      MODE_MOUNTAIN: begin m = M_W'(k) + M_W'(1); shift = 6'd31; end
      default:       begin m = M_W'(k);          shift = 6'd31; end
    endcase
    num = (NUM_W'(m) << shift) + NUM_W'(n >> 1);
  end

  logic             p_v_q;
  logic [NUM_W-1:0] p_num_q;
  logic [N_W-1:0]   p_n_q;
  meta_t            p_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_num_q  <= num;
      p_n_q    <= n;
      p_meta_q <= meta;
    end
  end

  logic             d_valid;
  logic [QUO_W-1:0] d_quo;
  meta_t            d_meta;

  sst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .num_i   (p_num_q),
    .den_i   (p_n_q),
    .meta_i  (p_meta_q),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .meta_o  (d_meta)
  );

  logic                    s_valid;
  logic signed [SIN_W-1:0] s_sine;
  logic                    s_zero;

  sst_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .frac_i  (d_quo),
    .meta_i  (d_meta),
    .valid_o (s_valid),
    .sine_o  (s_sine),
    .zero_o  (s_zero)
  );

  // amplitude scaling, rounding and saturation
  logic signed [AMP_W+SIN_W-1:0] prod;
  logic signed [AMP_W+SIN_W:0]   biased;
  logic signed [AMP_W+SIN_W-15:0] y;
  logic signed [OUT_W-1:0]       sat;

  assign prod   = amplitude_q * s_sine;
  assign biased = (AMP_W+SIN_W+1)'(prod) + (AMP_W+SIN_W+1)'(16384);
  assign y      = biased[AMP_W+SIN_W:15];

  always_comb begin
    if (y > (AMP_W+SIN_W-14)'(32767)) begin
      sat = 16'sh7fff;
    end else if (y < -(AMP_W+SIN_W-14)'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = y[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      shape_q <= s_zero ? '0 : sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shape_value_o = shape_q;

  // a waiting result holds off new transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result blocked");

  // a frozen pipeline keeps its valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(p_v_q) && $stable(d_valid) && $stable(s_valid)))
    else $error("pipeline moved while stalled");

endmodule
